// File: rtl/bsc_pkg.sv
// Shared types, constants and helper functions for the bracket and separator checker.
// No dependencies; every other file in rtl/ imports this package.
package bsc_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int LINE_BITS   = 16;
    localparam int COL_BITS    = 12;

    localparam int CNT_BITS   = $clog2(STACK_DEPTH + 1);
    localparam int PTR_BITS   = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = ((8 + LINE_BITS + COL_BITS + 7) / 8) * 8;

    localparam logic [CNT_BITS-1:0]  DEPTH_CNT = CNT_BITS'(STACK_DEPTH);
    localparam logic [LINE_BITS-1:0] LINE_MAX  = {LINE_BITS{1'b1}};
    localparam logic [COL_BITS-1:0]  COL_MAX   = {COL_BITS{1'b1}};

    // Opcodes of an input transfer.
    localparam logic [1:0] OP_CHAR = 2'd0;
    localparam logic [1:0] OP_EOL  = 2'd1;
    localparam logic [1:0] OP_EOT  = 2'd2;

    // Error kinds of a result transfer.
    localparam logic [1:0] ERR_SEPARATOR = 2'd0;
    localparam logic [1:0] ERR_UNMATCHED = 2'd1;
    localparam logic [1:0] ERR_UNCLOSED  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW  = 2'd3;

    // Bracket kinds as kept on the stack.
    localparam logic [1:0] BK_PAREN   = 2'd0;
    localparam logic [1:0] BK_SQUARE  = 2'd1;
    localparam logic [1:0] BK_CURLY   = 2'd2;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LSQ    = 8'h5B;
    localparam logic [7:0] CH_RSQ    = 8'h5D;
    localparam logic [7:0] CH_LCURLY = 8'h7B;
    localparam logic [7:0] CH_RCURLY = 8'h7D;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_UPPER_E = 8'h45;
    localparam logic [7:0] CH_UPPER_H = 8'h48;
    localparam logic [7:0] CH_UPPER_S = 8'h53;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_FLUSH_EMIT,
        ST_FLUSH_WAIT
    } ctrl_state_t;

    typedef enum logic [1:0] {
        STRIP_NONE,
        STRIP_PAREN,
        STRIP_BRACE,
        STRIP_MARK
    } strip_t;

    typedef struct packed {
        logic any;
        logic second;
        logic first_bar;
        logic comment;
        logic first_e;
        logic note;
        logic comma;
    } line_flags_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
    } stack_entry_t;

    typedef struct packed {
        logic [1:0]           kind;
        logic [7:0]           bracket;
        logic [LINE_BITS-1:0] line;
        logic [COL_BITS-1:0]  col;
        logic                 last;
    } result_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture the accepted input transfer
        logic exec;      // execute a character or end-of-line item
        logic pop_emit;  // report the top stack entry and pop it
        logic clear;     // return all text state to its reset value
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_eot;
        logic empty;
        logic last_entry;
        logic buf_free;
    } dp_status_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_note(input logic [7:0] c);
        return (c >= 8'h31 && c <= 8'h38) || (c >= 8'h61 && c <= 8'h65) ||
               (c >= 8'h41 && c <= 8'h45);
    endfunction

    function automatic logic [7:0] open_char(input logic [1:0] kind);
        logic [7:0] r;
        case (kind)
            BK_PAREN:  r = CH_LPAREN;
            BK_SQUARE: r = CH_LSQ;
            BK_CURLY:  r = CH_LCURLY;
            default:   r = CH_LPAREN;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/bsc_ctrl.sv
// Sequencing state machine for the bracket and separator checker.
// Depends on bsc_pkg; drives the datapath only through dp_cmd_t.
module bsc_ctrl
    import bsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.buf_free)
                begin
                    if (status.is_eot && !status.empty)
                    begin
                        state_next = ST_FLUSH_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_FLUSH_EMIT:
            begin
                if (status.buf_free)
                begin
                    state_next = status.last_entry ? ST_IDLE : ST_FLUSH_WAIT;
                end
            end
            ST_FLUSH_WAIT:
            begin
                state_next = ST_FLUSH_EMIT;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC:
            begin
                cmd.exec  = status.buf_free && !status.is_eot;
                cmd.clear = status.buf_free && status.is_eot && status.empty;
            end
            ST_FLUSH_EMIT:
            begin
                cmd.pop_emit = status.buf_free;
                cmd.clear    = status.buf_free && status.last_entry;
            end
            default:
            begin
            end
        endcase
    end

    // The flush only ever runs on a non-empty stack.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH_EMIT) |-> !status.empty)
        else $error("flush running on an empty stack");

    // Work commands never coincide with taking a new transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !(cmd.exec || cmd.pop_emit || cmd.clear))
        else $error("load overlaps with execution");

    // An item leaves the execute state only after acting on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && state_next == ST_IDLE) |-> (cmd.exec || cmd.clear))
        else $error("item dropped in execute state");

endmodule

// File: rtl/bsc_datapath.sv
// Datapath of the bracket and separator checker: input capture, line state,
// bracket stack memory and output register. Depends on bsc_pkg.
module bsc_datapath
    import bsc_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic [1:0]     in_opcode,
    input  logic [7:0]     in_char,
    input  dp_cmd_t        cmd,
    output dp_status_t     status,
    output logic           out_valid,
    input  logic           out_ready,
    output result_t        out_item
);

    logic [1:0]           op_reg;
    logic [7:0]           ch_reg;
    logic [CNT_BITS-1:0]  count_reg, count_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [COL_BITS-1:0]  col_reg, col_next;
    line_flags_t          flags_reg, flags_next;
    strip_t               strip_reg, strip_next;
    logic [1:0]           mark_reg, mark_next;
    logic                 out_valid_reg, out_valid_next;
    result_t              out_reg;
    stack_entry_t         rd_reg;
    stack_entry_t         stack_mem [STACK_DEPTH];

    logic                 emit;
    result_t              res;
    logic                 push;
    stack_entry_t         push_entry;
    logic [CNT_BITS-1:0]  cnt_m1;
    logic [PTR_BITS-1:0]  rd_addr;
    logic [PTR_BITS-1:0]  wr_addr;
    logic                 buf_free;

    assign buf_free = !out_valid_reg || out_ready;
    assign cnt_m1   = count_reg - 1'b1;
    assign rd_addr  = cnt_m1[PTR_BITS-1:0];
    assign wr_addr  = count_reg[PTR_BITS-1:0];

    always_comb
    begin
        status.is_eot     = (op_reg == OP_EOT);
        status.empty      = (count_reg == '0);
        status.last_entry = (count_reg == CNT_BITS'(1));
        status.buf_free   = buf_free;
    end

    always_comb
    begin
        logic [COL_BITS-1:0] col_inc;
        logic                stop;
        logic                is_open;
        logic                is_close;
        logic [1:0]          bkind;

        count_next = count_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        flags_next = flags_reg;
        strip_next = strip_reg;
        mark_next  = mark_reg;
        emit       = 1'b0;
        res        = '0;
        push       = 1'b0;
        push_entry = '0;
        col_inc    = (col_reg == COL_MAX) ? col_reg : col_reg + 1'b1;
        stop       = 1'b0;
        is_open    = 1'b0;
        is_close   = 1'b0;
        bkind      = BK_PAREN;

        case (ch_reg)
            CH_LPAREN: begin is_open  = 1'b1; bkind = BK_PAREN;  end
            CH_LSQ:    begin is_open  = 1'b1; bkind = BK_SQUARE; end
            CH_LCURLY: begin is_open  = 1'b1; bkind = BK_CURLY;  end
            CH_RPAREN: begin is_close = 1'b1; bkind = BK_PAREN;  end
            CH_RSQ:    begin is_close = 1'b1; bkind = BK_SQUARE; end
            CH_RCURLY: begin is_close = 1'b1; bkind = BK_CURLY;  end
            default:   begin end
        endcase

        if (cmd.pop_emit)
        begin
            count_next  = cnt_m1;
            emit        = 1'b1;
            res.kind    = ERR_UNCLOSED;
            res.bracket = open_char(rd_reg.kind);
            res.line    = rd_reg.line;
            res.col     = rd_reg.col;
            res.last    = status.last_entry;
        end
        else if (cmd.exec)
        begin
            case (op_reg)
                OP_CHAR:
                begin
                    col_next = col_inc;
                    if (flags_reg.comment)
                    begin
                        stop = 1'b1;
                    end
                    else if (!is_blank(ch_reg))
                    begin
                        if (!flags_reg.any)
                        begin
                            flags_next.any       = 1'b1;
                            flags_next.first_bar = (ch_reg == CH_BAR);
                            flags_next.first_e   = (ch_reg == CH_UPPER_E);
                        end
                        else if (!flags_reg.second)
                        begin
                            flags_next.second = 1'b1;
                            if (flags_reg.first_bar && ch_reg == CH_BAR)
                            begin
                                flags_next.comment = 1'b1;
                                stop               = 1'b1;
                            end
                        end
                    end

                    if (!stop)
                    begin
                        // Track which parts of the line count as stripped.
                        case (strip_reg)
                            STRIP_PAREN:
                            begin
                                if (ch_reg == CH_RPAREN) strip_next = STRIP_NONE;
                            end
                            STRIP_BRACE:
                            begin
                                if (ch_reg == CH_RCURLY) strip_next = STRIP_NONE;
                            end
                            STRIP_MARK:
                            begin
                                if (ch_reg == CH_GT) strip_next = STRIP_NONE;
                            end
                            default:
                            begin
                                if (ch_reg == CH_LPAREN)
                                begin
                                    strip_next = STRIP_PAREN;
                                    mark_next  = 2'd0;
                                end
                                else if (ch_reg == CH_LCURLY)
                                begin
                                    strip_next = STRIP_BRACE;
                                    mark_next  = 2'd0;
                                end
                                else if (ch_reg == CH_STAR && mark_reg == 2'd2)
                                begin
                                    strip_next = STRIP_MARK;
                                    mark_next  = 2'd0;
                                end
                                else
                                begin
                                    if (ch_reg == CH_UPPER_H)
                                        mark_next = 2'd1;
                                    else if (ch_reg == CH_UPPER_S && mark_reg == 2'd1)
                                        mark_next = 2'd2;
                                    else
                                        mark_next = 2'd0;
                                    if (ch_reg == CH_COMMA) flags_next.comma = 1'b1;
                                    if (is_note(ch_reg))    flags_next.note  = 1'b1;
                                end
                            end
                        endcase

                        // Bracket stack.
                        res.bracket = ch_reg;
                        res.line    = line_reg;
                        res.col     = col_inc;
                        res.last    = 1'b1;
                        if (is_open)
                        begin
                            if (count_reg == DEPTH_CNT)
                            begin
                                emit     = 1'b1;
                                res.kind = ERR_OVERFLOW;
                            end
                            else
                            begin
                                push            = 1'b1;
                                push_entry.kind = bkind;
                                push_entry.line = line_reg;
                                push_entry.col  = col_inc;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        else if (is_close)
                        begin
                            if (count_reg == '0 || rd_reg.kind != bkind)
                            begin
                                emit     = 1'b1;
                                res.kind = ERR_UNMATCHED;
                            end
                            else
                            begin
                                count_next = cnt_m1;
                            end
                        end
                    end
                end
                OP_EOL:
                begin
                    if (flags_reg.any && !flags_reg.comment &&
                        !(flags_reg.first_e && !flags_reg.second) &&
                        flags_reg.note && !flags_reg.comma)
                    begin
                        emit        = 1'b1;
                        res.kind    = ERR_SEPARATOR;
                        res.bracket = 8'd0;
                        res.line    = line_reg;
                        res.col     = COL_BITS'(1);
                        res.last    = 1'b1;
                    end
                    line_next  = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
                    col_next   = '0;
                    flags_next = '0;
                    strip_next = STRIP_NONE;
                    mark_next  = 2'd0;
                end
                default:
                begin
                end
            endcase
        end

        if (cmd.clear)
        begin
            count_next = '0;
            line_next  = LINE_BITS'(1);
            col_next   = '0;
            flags_next = '0;
            strip_next = STRIP_NONE;
            mark_next  = 2'd0;
        end
    end

    assign out_valid_next = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            line_reg      <= LINE_BITS'(1);
            col_reg       <= '0;
            flags_reg     <= '0;
            strip_reg     <= STRIP_NONE;
            mark_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            flags_reg     <= flags_next;
            strip_reg     <= strip_next;
            mark_reg      <= mark_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg <= in_opcode;
            ch_reg <= in_char;
        end
        if (emit)
        begin
            out_reg <= res;
        end
    end

    // Stack memory: one write and one registered read of the top entry per cycle.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            stack_mem[wr_addr] <= push_entry;
        end
        rd_reg <= stack_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("stack count beyond depth");

    assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("push did not grow the stack");

    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.kind == ERR_SEPARATOR) |->
            (out_reg.bracket == 8'd0 && out_reg.col == COL_BITS'(1)))
        else $error("separator error carries a bracket or column");

    assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line number wrapped to zero");

endmodule

// File: rtl/bracket_and_separator_checker_unit.sv
// Top level of the bracket and separator checker: stream ports, controller
// and datapath. Depends on bsc_pkg, bsc_ctrl and bsc_datapath.
//
// The checker reads a text one transfer at a time: a character, an end of
// line or an end of text, selected by s_tuser. It keeps a stack of the open
// brackets ( [ { with the line and column of each and reports, as result
// transfers, a closing bracket that is unmatched, an opening bracket that
// finds the stack full, and a line that holds lane digits or note letters in
// its stripped text but no comma (reported at the end of that line, after
// the line's bracket errors). At end of text every bracket still open is
// reported from the top of the stack down, tlast marking the final one, and
// all text state returns to its reset value. A character or end-of-line
// transfer is first taken and then executed against the top-of-stack entry,
// which comes from the registered read port of the stack memory. At end of
// text every pop but the last is followed by a wait for the memory read of
// the new top. A result waits in the output register while the next input
// transfer is taken; the execute step of that transfer, and each flush step,
// stalls until the waiting result has been taken. Line and column numbers
// saturate at their largest values.
module bracket_and_separator_checker_unit
    import bsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] char_code
    input  logic [1:0]            s_tuser,   // [1:0] opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // bracket_char, line_number, column_number, zero fill
    output logic [1:0]            m_tuser,   // [1:0] error_kind
    output logic                  m_tlast
);

    dp_cmd_t    cmd;
    dp_status_t status;
    result_t    out_item;

    bsc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bsc_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_opcode (s_tuser),
        .in_char   (s_tdata[7:0]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    // Result fields are packed with the bracket character in the lowest byte.
    assign m_tdata = OUT_DATA_W'({out_item.col, out_item.line, out_item.bracket});
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

endmodule
